### sv/tcts_pkg.sv
// ----------------------------------------------------------------------------
// tcts_pkg
// Shared types, codes and helpers of the three-color Turing stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package tcts_pkg;

   // Sizes of the machine
   localparam int STATE_COUNT = 16;
   localparam int CELL_COUNT  = 256;
   localparam int RULE_DEPTH  = STATE_COUNT * 3;
   localparam int RULE_AW     = $clog2(RULE_DEPTH);
   localparam int CELL_AW     = $clog2(CELL_COUNT);

   // Field widths
   localparam int COLOR_W = 2;
   localparam int STATE_W = 5;
   localparam int MOVE_W  = 2;
   localparam int POS_W   = 8;
   localparam int CNT_W   = 9;
   localparam int STAT_W  = 3;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 9;

   // Request kinds
   localparam logic [1:0] REQ_STEP    = 2'd0;
   localparam logic [1:0] REQ_RULE    = 2'd1;
   localparam logic [1:0] REQ_TAPE    = 2'd2;
   localparam logic [1:0] REQ_RESTART = 2'd3;

   // Head moves
   localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd0;
   localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd1;
   localparam logic [MOVE_W-1:0] MOVE_CONT  = 2'd2;

   localparam logic [COLOR_W-1:0] COLOR_BAD = 2'd3;

   // Result status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STAT_W-1:0] STAT_HALTED   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_LEFT_END = 3'd2;
   localparam logic [STAT_W-1:0] STAT_RIGHT_END = 3'd3;
   localparam logic [STAT_W-1:0] STAT_BAD_POS  = 3'd4;
   localparam logic [STAT_W-1:0] STAT_BAD_COLOR = 3'd5;
   localparam logic [STAT_W-1:0] STAT_NO_CONT  = 3'd6;

   // Configuration register indexes
   localparam logic [CSR_AW-1:0] CSR_CELLS_IN_USE   = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_START_STATE    = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_START_POSITION = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [3:0]         rule_state;
      logic [COLOR_W-1:0] rule_color;
      logic [COLOR_W-1:0] rule_next_color;
      logic [STATE_W-1:0] rule_next_state;
      logic [MOVE_W-1:0]  rule_move;
      logic [POS_W-1:0]   cell_index;
      logic [COLOR_W-1:0] cell_color;
   } req_item_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic               done_flag;
      logic [POS_W-1:0]   head_position;
      logic [STATE_W-1:0] machine_state;
      logic               write_valid;
      logic [POS_W-1:0]   written_index;
      logic [COLOR_W-1:0] written_color;
   } rsp_item_type;

   // One entry of the rule table
   typedef struct packed {
      logic [MOVE_W-1:0]  move;
      logic [STATE_W-1:0] next_state;
      logic [COLOR_W-1:0] next_color;
   } rule_type;

   // Rule table address: state * 3 + color
   function automatic logic [RULE_AW-1:0] rule_addr(input logic [STATE_W-1:0] st,
                                                    input logic [COLOR_W-1:0] col);
      logic [RULE_AW-1:0] s;
      s = RULE_AW'(st);
      return (s << 1) + s + RULE_AW'(col);
   endfunction

   // Any state index at or beyond the state count is a halt state
   function automatic logic is_halt(input logic [STATE_W-1:0] st);
      return CNT_W'(st) >= CNT_W'(STATE_COUNT);
   endfunction

endpackage

`default_nettype wire

### sv/tcts_tape_mem.sv
// ----------------------------------------------------------------------------
// tcts_tape_mem
// Tape store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcts_tape_mem
   import tcts_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               rd_en,
   input  wire logic [CELL_AW-1:0] rd_addr,
   output logic      [COLOR_W-1:0] rd_data,
   input  wire logic               wr_en,
   input  wire logic [CELL_AW-1:0] wr_addr,
   input  wire logic [COLOR_W-1:0] wr_data
);

   logic [COLOR_W-1:0] mem [CELL_COUNT];
   logic [COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold the read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/tcts_rule_mem.sv
// ----------------------------------------------------------------------------
// tcts_rule_mem
// Rule table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcts_rule_mem
   import tcts_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               rd_en,
   input  wire logic [RULE_AW-1:0] rd_addr,
   output rule_type                rd_data,
   input  wire logic               wr_en,
   input  wire logic [RULE_AW-1:0] wr_addr,
   input  wire rule_type           wr_data
);

   rule_type mem [RULE_DEPTH];
   rule_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold the read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/three_color_turing_stepper_unit.sv
// ----------------------------------------------------------------------------
// three_color_turing_stepper_unit
// Turing machine over a three-color tape, driven one request at a time.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. For a step request the transfer
// issues the tape read at the head, the tape state looks up the rule for
// state and color, and at commit the new color is written back, head and
// state are updated and the result register is loaded. Rule loads, tape
// loads, restarts and steps that stop before touching the tape go from idle
// straight to the finish state. Two dependent synchronous memory reads lie
// on the step path. The result register parts the two sides: a new request
// is taken while an earlier result waits, and the write-back holds only
// while that result is still stalled. Tape and rule table come up undefined
// and need no clearing after reset; load them before stepping.
// Write the configuration registers only while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module three_color_turing_stepper_unit
   import tcts_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_item_type      req_data,

   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_item_type           rsp_data,

   input  wire logic              csr_wr_en,
   input  wire logic [CSR_AW-1:0] csr_index,
   input  wire logic [CSR_DW-1:0] csr_wr_data
);

   // Sequencer: idle, tape read pending, rule read pending, result pending
   typedef enum logic [3:0] {
      FSM_IDLE = 4'b0001,
      FSM_TAPE = 4'b0010,
      FSM_RULE = 4'b0100,
      FSM_FIN  = 4'b1000
   } fsm_type;

   fsm_type fsm_ff, fsm_in;

   // Configuration registers
   logic [CNT_W-1:0]  cells_in_use_ff;
   logic [3:0]        start_state_ff;
   logic [POS_W-1:0]  start_position_ff;

   // Machine registers
   logic [POS_W-1:0]   head_ff, head_in;
   logic [STATE_W-1:0] mstate_ff, mstate_in;
   logic               stopped_ff, stopped_in;
   logic [MOVE_W-1:0]  last_move_ff, last_move_in;

   // Request held while it is worked on
   req_item_type item_ff;

   // Result register
   logic         rsp_valid_ff;
   rsp_item_type rsp_ff, rsp_in;

   // Memory ports
   logic               tape_rd_en, tape_we;
   logic [CELL_AW-1:0] tape_waddr;
   logic [COLOR_W-1:0] tape_rd, tape_wdata;
   logic               rule_rd_en, rule_we;
   rule_type           rule_rd, rule_wdata;

   logic             req_xfer, commit, slot_free;
   logic [CNT_W-1:0] usable;
   logic             head_ok, head_up_ok, step_go;
   logic [MOVE_W-1:0] dir;
   logic             dir_ok;
   logic [STAT_W-1:0] status;

   // ------------------------------------------------------------------
   // Configuration writes
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cells_in_use_ff   <= CNT_W'(256);
         start_state_ff    <= '0;
         start_position_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CELLS_IN_USE:   cells_in_use_ff   <= csr_wr_data;
            CSR_START_STATE:    start_state_ff    <= csr_wr_data[3:0];
            CSR_START_POSITION: start_position_ff <= csr_wr_data[POS_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Head limits: usable length is the register clamped to the tape size
   // ------------------------------------------------------------------
   assign usable     = (cells_in_use_ff < CNT_W'(CELL_COUNT)) ? cells_in_use_ff
                                                              : CNT_W'(CELL_COUNT);
   assign head_ok    = CNT_W'(head_ff) < usable;
   assign head_up_ok = (CNT_W'(head_ff) + CNT_W'(1)) < usable;

   // ------------------------------------------------------------------
   // Handshakes
   // ------------------------------------------------------------------
   assign req_stall = (fsm_ff != FSM_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign commit    = ((fsm_ff == FSM_RULE) || (fsm_ff == FSM_FIN)) && slot_free;

   // A step touches the tape only if the machine runs and the head is inside
   assign step_go = (req_data.req_type == REQ_STEP) && !stopped_ff &&
                    !is_halt(mstate_ff) && head_ok;

   // ------------------------------------------------------------------
   // Sequencer. Reads happen only in idle and tape cycles and writes only
   // at commit, so a read and a write never meet on the same entry.
   // ------------------------------------------------------------------
   always_comb begin
      fsm_in     = fsm_ff;
      tape_rd_en = 1'b0;
      rule_rd_en = 1'b0;
      case (fsm_ff)
         FSM_IDLE: begin
            if (req_xfer) begin
               tape_rd_en = step_go;
               fsm_in     = step_go ? FSM_TAPE : FSM_FIN;
            end
         end
         FSM_TAPE: begin
            // Drop the rule lookup when the cell holds no valid color
            if (tape_rd == COLOR_BAD) begin
               fsm_in = FSM_FIN;
            end else begin
               rule_rd_en = 1'b1;
               fsm_in     = FSM_RULE;
            end
         end
         FSM_RULE: begin
            fsm_in = commit ? FSM_IDLE : FSM_FIN;
         end
         FSM_FIN: begin
            if (commit) begin
               fsm_in = FSM_IDLE;
            end
         end
         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= FSM_IDLE;
      end else begin
         fsm_ff <= fsm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff <= req_data;
      end
   end

   // ------------------------------------------------------------------
   // Memories
   // ------------------------------------------------------------------
   tcts_tape_mem u_tape (
      .clock   (clock),
      .rd_en   (tape_rd_en),
      .rd_addr (head_ff[CELL_AW-1:0]),
      .rd_data (tape_rd),
      .wr_en   (tape_we),
      .wr_addr (tape_waddr),
      .wr_data (tape_wdata)
   );

   tcts_rule_mem u_rule (
      .clock   (clock),
      .rd_en   (rule_rd_en),
      .rd_addr (rule_addr(mstate_ff, tape_rd)),
      .rd_data (rule_rd),
      .wr_en   (rule_we),
      .wr_addr (rule_addr(STATE_W'(item_ff.rule_state), item_ff.rule_color)),
      .wr_data (rule_wdata)
   );

   assign rule_wdata.move       = item_ff.rule_move;
   assign rule_wdata.next_state = item_ff.rule_next_state;
   assign rule_wdata.next_color = item_ff.rule_next_color;

   // ------------------------------------------------------------------
   // Head move for a step: the rule's own move, or repeat the last one.
   // A move code of three counts as continue.
   // ------------------------------------------------------------------
   always_comb begin
      dir    = rule_rd.move;
      dir_ok = 1'b1;
      if ((rule_rd.move != MOVE_LEFT) && (rule_rd.move != MOVE_RIGHT)) begin
         dir    = last_move_ff;
         dir_ok = (last_move_ff != MOVE_CONT);
      end
   end

   // ------------------------------------------------------------------
   // Write-back: the effects of the held request, applied at commit.
   // The machine registers have not changed since the transfer, so the
   // early-stop checks give the same answer as they did then.
   // ------------------------------------------------------------------
   always_comb begin
      head_in      = head_ff;
      mstate_in    = mstate_ff;
      stopped_in   = stopped_ff;
      last_move_in = last_move_ff;
      status       = STAT_OK;
      tape_we      = 1'b0;
      tape_waddr   = head_ff[CELL_AW-1:0];
      tape_wdata   = rule_rd.next_color;
      rule_we      = 1'b0;
      rsp_in.write_valid   = 1'b0;
      rsp_in.written_index = '0;
      rsp_in.written_color = '0;

      case (item_ff.req_type)
         REQ_RULE: begin
            rule_we = (CNT_W'(item_ff.rule_state) < CNT_W'(STATE_COUNT)) &&
                      (item_ff.rule_color != COLOR_BAD);
         end
         REQ_TAPE: begin
            tape_we    = CNT_W'(item_ff.cell_index) < CNT_W'(CELL_COUNT);
            tape_waddr = CELL_AW'(item_ff.cell_index);
            tape_wdata = item_ff.cell_color;
         end
         REQ_RESTART: begin
            head_in      = start_position_ff;
            mstate_in    = STATE_W'(start_state_ff);
            stopped_in   = 1'b0;
            last_move_in = MOVE_CONT;
         end
         REQ_STEP: begin
            if (!stopped_ff) begin
               if (is_halt(mstate_ff)) begin
                  stopped_in = 1'b1;
                  status     = STAT_HALTED;
               end else if (!head_ok) begin
                  stopped_in = 1'b1;
                  status     = STAT_BAD_POS;
               end else if (tape_rd == COLOR_BAD) begin
                  stopped_in = 1'b1;
                  status     = STAT_BAD_COLOR;
               end else begin
                  // Write the cell and take the next state, then move
                  tape_we              = 1'b1;
                  rsp_in.write_valid   = 1'b1;
                  rsp_in.written_index = head_ff;
                  rsp_in.written_color = rule_rd.next_color;
                  mstate_in            = rule_rd.next_state;
                  if (is_halt(rule_rd.next_state)) begin
                     stopped_in = 1'b1;
                     status     = STAT_HALTED;
                  end else if (!dir_ok) begin
                     stopped_in = 1'b1;
                     status     = STAT_NO_CONT;
                  end else if (dir == MOVE_LEFT) begin
                     if (head_ff != '0) begin
                        head_in      = head_ff - POS_W'(1);
                        last_move_in = MOVE_LEFT;
                     end else begin
                        stopped_in = 1'b1;
                        status     = STAT_LEFT_END;
                     end
                  end else begin
                     if (head_up_ok) begin
                        head_in      = head_ff + POS_W'(1);
                        last_move_in = MOVE_RIGHT;
                     end else begin
                        stopped_in = 1'b1;
                        status     = STAT_RIGHT_END;
                     end
                  end
               end
            end
         end
         default: ;
      endcase

      tape_we = tape_we && commit;
      rule_we = rule_we && commit;

      rsp_in.status        = status;
      rsp_in.done_flag     = stopped_in;
      rsp_in.head_position = head_in;
      rsp_in.machine_state = mstate_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         mstate_ff    <= '0;
         stopped_ff   <= 1'b0;
         last_move_ff <= MOVE_CONT;
      end else if (commit) begin
         head_ff      <= head_in;
         mstate_ff    <= mstate_in;
         stopped_ff   <= stopped_in;
         last_move_ff <= last_move_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register: load at commit, advance on transfer
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
